>>> rtl/irqrr_pkg.sv
package irqrr_pkg;

    typedef enum logic [2:0] {
        OP_CLAIM    = 3'd0,
        OP_RELEASE  = 3'd1,
        OP_AFFINITY = 3'd2,
        OP_APIC     = 3'd3,
        OP_MSI      = 3'd4
    } op_t;

    typedef enum logic [2:0] {
        KIND_CLAIMED  = 3'd0,
        KIND_NO_SLOT  = 3'd1,
        KIND_RELEASED = 3'd2,
        KIND_LOCAL    = 3'd3,
        KIND_FORWARD  = 3'd4
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLAIM,
        ST_REL,
        ST_SCAN,
        ST_DSP
    } st_t;

    localparam logic [1:0] CFG_LOCAL  = 2'd0;
    localparam logic [1:0] CFG_ACTIVE = 2'd1;
    localparam logic [1:0] CFG_BASE   = 2'd2;

    localparam int QDEPTH = 2;

    typedef struct packed {
        op_t         op;
        logic        irq_ok;
        logic [6:0]  irq;
        logic [15:0] mask;
        logic [63:0] pend;
        logic [3:0]  self_cpu;
    } cmd_t;

    typedef struct packed {
        kind_t      kind;
        logic [4:0] slot;
        logic [5:0] source;
        logic [6:0] irq;
        logic [3:0] cpu;
        logic       last;
    } res_t;

endpackage

>>> rtl/irqrr_ram.sv
module irqrr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> rtl/irqrr_front.sv
module irqrr_front #(
    parameter int NUM_IRQS    = 128,
    parameter int NUM_SOURCES = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic [2:0]         command,
    input  logic [6:0]         irq_number,
    input  logic [15:0]        cpu_mask,
    input  logic [63:0]        pending,
    input  logic [3:0]         self_cpu,
    output logic               q_valid,
    input  logic               q_ready,
    output irqrr_pkg::cmd_t    q_cmd
);
    import irqrr_pkg::*;

    localparam logic [63:0] SRC_MASK =
        (NUM_SOURCES >= 64) ? 64'hFFFF_FFFF_FFFF_FFFF : ((64'd1 << NUM_SOURCES) - 64'd1);

    cmd_t       entry_reg [QDEPTH];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    cmd_t       cls;
    logic       keep;
    logic       do_push, do_pop;

    // Classify the beat: unused codes, empty dispatches and out-of-range
    // affinity writes produce nothing and are dropped here.
    always_comb
    begin
        cls.op       = op_t'(command);
        cls.irq_ok   = (32'(irq_number) < NUM_IRQS);
        cls.irq      = irq_number;
        cls.mask     = cpu_mask;
        cls.pend     = pending & SRC_MASK;
        cls.self_cpu = self_cpu;
        unique case (command)
            OP_CLAIM, OP_RELEASE: keep = 1'b1;
            OP_AFFINITY:          keep = cls.irq_ok;
            OP_APIC, OP_MSI:      keep = (cls.pend != 64'd0);
            default:              keep = 1'b0;
        endcase
    end

    assign full    = (count_reg == 2'(QDEPTH));
    assign q_valid = (count_reg != 2'd0);
    assign q_cmd   = entry_reg[rd_ptr_reg];
    assign do_push = push && !full && keep;
    assign do_pop  = q_valid && q_ready;

    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= cls;
        end
    end

endmodule

>>> rtl/irqrr_back.sv
module irqrr_back #(
    parameter int NUM_CPUS    = 16,
    parameter int NUM_SLOTS   = 26,
    parameter int NUM_IRQS    = 128,
    parameter int NUM_SOURCES = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    output logic               q_ready,
    input  irqrr_pkg::cmd_t    q_cmd,
    input  logic               cfg_valid,
    input  logic [1:0]         cfg_index,
    input  logic [63:0]        cfg_data,
    input  logic               pop,
    output logic               empty,
    output irqrr_pkg::res_t    res
);
    import irqrr_pkg::*;

    localparam int IRQ_AW   = $clog2(NUM_IRQS);
    localparam int SRC_AW   = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;
    localparam int RR_AW    = SRC_AW + 1;
    localparam int RR_DEPTH = 2 ** RR_AW;
    localparam logic [15:0] CPU_LIM =
        (NUM_CPUS >= 16) ? 16'hFFFF : 16'((32'd1 << NUM_CPUS) - 32'd1);

    st_t                  state_reg, state_next;
    cmd_t                 cmd_reg, cmd_next;
    logic [5:0]           src_reg, src_next;
    logic [63:0]          pend_reg, pend_next;
    logic [NUM_SLOTS-1:0] busy_reg, busy_next;
    logic [NUM_IRQS-1:0]  map_valid_reg, map_valid_next;
    logic [NUM_IRQS-1:0]  aff_valid_reg, aff_valid_next;
    logic [RR_DEPTH-1:0]  rr_valid_reg, rr_valid_next;
    logic [63:0]          local_reg;
    logic [15:0]          active_reg;
    logic [6:0]           base_reg;
    logic                 out_valid_reg, out_valid_next;
    res_t                 out_reg, out_next;

    logic              map_we, map_re;
    logic [IRQ_AW-1:0] map_waddr, map_raddr;
    logic [4:0]        map_wdata, map_rdata;
    logic              aff_we, aff_re;
    logic [IRQ_AW-1:0] aff_waddr;
    logic [15:0]       aff_rdata;
    logic              rr_we, rr_re;
    logic [RR_AW-1:0]  rr_addr;
    logic [3:0]        rr_rdata;

    logic              out_free, load;
    logic              msi, in_tab, has_slot, force_local, found;
    logic [7:0]        idx_wide;
    logic [IRQ_AW-1:0] irq_addr, cmd_addr;
    logic [4:0]        claim_pos;
    logic [15:0]       aff, avail, hi;
    logic [3:0]        tgt;
    res_t              res_v;

    function automatic logic [3:0] lowest(input logic [15:0] v);
        logic [3:0] p;
        p = 4'd0;
        for (int c = 15; c >= 0; c--)
        begin
            if (v[c])
            begin
                p = 4'(c);
            end
        end
        return p;
    endfunction

    irqrr_ram #(.WIDTH(5), .DEPTH(NUM_IRQS)) u_map_ram (
        .clk(clk), .we(map_we), .waddr(map_waddr), .wdata(map_wdata),
        .re(map_re), .raddr(map_raddr), .rdata(map_rdata)
    );

    irqrr_ram #(.WIDTH(16), .DEPTH(NUM_IRQS)) u_aff_ram (
        .clk(clk), .we(aff_we), .waddr(aff_waddr), .wdata(q_cmd.mask),
        .re(aff_re), .raddr(irq_addr), .rdata(aff_rdata)
    );

    irqrr_ram #(.WIDTH(4), .DEPTH(RR_DEPTH)) u_rr_ram (
        .clk(clk), .we(rr_we), .waddr(rr_addr), .wdata(tgt),
        .re(rr_re), .raddr(rr_addr), .rdata(rr_rdata)
    );

    assign empty    = !out_valid_reg;
    assign res      = out_reg;
    assign q_ready  = (state_reg == ST_IDLE);
    assign out_free = !out_valid_reg || pop;

    // Address and per-source decision for the source at the scan position.
    always_comb
    begin
        msi       = (cmd_reg.op == OP_MSI);
        idx_wide  = msi ? {2'b00, src_reg} : ({1'b0, base_reg} + {2'b00, src_reg});
        in_tab    = (32'(idx_wide) < NUM_IRQS);
        irq_addr  = IRQ_AW'(idx_wide);
        cmd_addr  = IRQ_AW'(cmd_reg.irq);
        rr_addr   = {msi, SRC_AW'(src_reg)};
        has_slot  = in_tab && map_valid_reg[irq_addr];
        aff       = aff_valid_reg[irq_addr] ? aff_rdata : 16'hFFFF;
        avail     = in_tab ? (aff & active_reg & CPU_LIM) : 16'd0;
        force_local = (!msi && (local_reg[src_reg] || !has_slot)) || (avail == 16'd0);
        hi        = rr_valid_reg[rr_addr] ? (avail & ~((16'd2 << rr_rdata) - 16'd1)) : avail;
        tgt       = lowest((hi != 16'd0) ? hi : avail);
        found     = 1'b0;
        claim_pos = 5'd0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--)
        begin
            if (!busy_reg[i])
            begin
                found     = 1'b1;
                claim_pos = 5'(i);
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    unique case (q_cmd.op)
                        OP_CLAIM:        state_next = ST_CLAIM;
                        OP_RELEASE:      state_next = ST_REL;
                        OP_APIC, OP_MSI: state_next = ST_SCAN;
                        default:         state_next = ST_IDLE;
                    endcase
                end
            end
            ST_CLAIM, ST_REL:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SCAN:
            begin
                if (pend_reg[0])
                begin
                    state_next = ST_DSP;
                end
            end
            ST_DSP:
            begin
                if (out_free)
                begin
                    state_next = (pend_reg[63:1] == 63'd0) ? ST_IDLE : ST_SCAN;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd_next       = cmd_reg;
        src_next       = src_reg;
        pend_next      = pend_reg;
        busy_next      = busy_reg;
        map_valid_next = map_valid_reg;
        aff_valid_next = aff_valid_reg;
        rr_valid_next  = rr_valid_reg;
        map_we         = 1'b0;
        map_waddr      = cmd_addr;
        map_wdata      = claim_pos;
        map_re         = 1'b0;
        map_raddr      = irq_addr;
        aff_we         = 1'b0;
        aff_waddr      = IRQ_AW'(q_cmd.irq);
        aff_re         = 1'b0;
        rr_we          = 1'b0;
        rr_re          = 1'b0;
        load           = 1'b0;
        res_v          = '{kind: KIND_LOCAL, slot: 5'd0, source: src_reg,
                           irq: idx_wide[6:0], cpu: cmd_reg.self_cpu,
                           last: (pend_reg[63:1] == 63'd0)};
        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    cmd_next  = q_cmd;
                    src_next  = 6'd0;
                    pend_next = q_cmd.pend;
                    map_re    = 1'b1;
                    map_raddr = IRQ_AW'(q_cmd.irq);
                    if (q_cmd.op == OP_AFFINITY)
                    begin
                        aff_we = 1'b1;
                        aff_valid_next[IRQ_AW'(q_cmd.irq)] = 1'b1;
                    end
                end
            end
            ST_CLAIM:
            begin
                if (out_free)
                begin
                    load = 1'b1;
                    res_v = '{kind: KIND_NO_SLOT, slot: 5'd0, source: 6'd0,
                              irq: cmd_reg.irq, cpu: 4'd0, last: 1'b1};
                    if (found && cmd_reg.irq_ok)
                    begin
                        res_v.kind = KIND_CLAIMED;
                        res_v.slot = claim_pos;
                        busy_next  = busy_reg | (NUM_SLOTS'(1) << claim_pos);
                        map_we     = 1'b1;
                        map_valid_next[cmd_addr] = 1'b1;
                    end
                end
            end
            ST_REL:
            begin
                if (out_free)
                begin
                    load = 1'b1;
                    res_v = '{kind: KIND_RELEASED, slot: 5'd0, source: 6'd0,
                              irq: cmd_reg.irq, cpu: 4'd0, last: 1'b1};
                    if (cmd_reg.irq_ok && map_valid_reg[cmd_addr])
                    begin
                        res_v.slot = map_rdata;
                        busy_next  = busy_reg & ~(NUM_SLOTS'(1) << map_rdata);
                        map_valid_next[cmd_addr] = 1'b0;
                    end
                end
            end
            ST_SCAN:
            begin
                if (pend_reg[0])
                begin
                    map_re = 1'b1;
                    aff_re = 1'b1;
                    rr_re  = 1'b1;
                end
                else
                begin
                    pend_next = pend_reg >> 1;
                    src_next  = src_reg + 6'd1;
                end
            end
            ST_DSP:
            begin
                if (out_free)
                begin
                    load      = 1'b1;
                    pend_next = pend_reg >> 1;
                    src_next  = src_reg + 6'd1;
                    if (!force_local)
                    begin
                        // The pointer moves even when the receiver itself is chosen.
                        rr_we = 1'b1;
                        rr_valid_next[rr_addr] = 1'b1;
                        if (tgt != cmd_reg.self_cpu && has_slot)
                        begin
                            res_v.kind = KIND_FORWARD;
                            res_v.slot = map_rdata;
                            res_v.cpu  = tgt;
                        end
                    end
                end
            end
            default: ;
        endcase
        out_next       = load ? res_v : out_reg;
        out_valid_next = load || (out_valid_reg && !pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            busy_reg      <= '0;
            map_valid_reg <= '0;
            aff_valid_reg <= '0;
            rr_valid_reg  <= '0;
            out_valid_reg <= 1'b0;
            local_reg     <= 64'd0;
            active_reg    <= 16'd1;
            base_reg      <= 7'd0;
        end
        else
        begin
            state_reg     <= state_next;
            busy_reg      <= busy_next;
            map_valid_reg <= map_valid_next;
            aff_valid_reg <= aff_valid_next;
            rr_valid_reg  <= rr_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid)
            begin
                case (cfg_index)
                    CFG_LOCAL:  local_reg  <= cfg_data;
                    CFG_ACTIVE: active_reg <= cfg_data[15:0];
                    CFG_BASE:   base_reg   <= cfg_data[6:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg  <= cmd_next;
        src_reg  <= src_next;
        pend_reg <= pend_next;
        out_reg  <= out_next;
    end

`ifndef NO_ASSERTIONS
    a_busy_only_claim_rel: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_CLAIM && state_reg != ST_REL) |=> $stable(busy_reg))
        else $error("slot pool changed outside claim or release");

    a_scan_has_work: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (pend_reg != 64'd0))
        else $error("scan running with no pending source left");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !pop) |=> (out_valid_reg && $stable(out_reg)))
        else $error("waiting result overwritten");
`endif

endmodule

>>> rtl/interrupt_round_robin_distributor.sv
// Claim and release: when the back end is idle, a taken beat passes from the command queue
// into the back end's command register and then into the result register on the ports.
// Dispatch: the back end takes the command, steps through each bit position up to the highest
// pending source, and for each set source adds a dispatch step that waits for the output.
// A two-entry command queue lets new beats in while the back end works.
// Reset is asynchronous and takes effect at once: the tables read as their reset
// values through valid bits, so no clearing pass is needed.
module interrupt_round_robin_distributor #(
    parameter int NUM_CPUS    = 16,
    parameter int NUM_SLOTS   = 26,
    parameter int NUM_IRQS    = 128,
    parameter int NUM_SOURCES = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [2:0]  command,
    input  logic [6:0]  irq_number,
    input  logic [15:0] cpu_mask,
    input  logic [63:0] pending,
    input  logic [3:0]  self_cpu,
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  kind,
    output logic [4:0]  slot,
    output logic [5:0]  source,
    output logic [6:0]  handled_irq,
    output logic [3:0]  target_cpu,
    output logic        last,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data
);
    import irqrr_pkg::*;

    logic q_valid, q_ready;
    cmd_t q_cmd;
    res_t res;

    assign cfg_ready = 1'b1;

    irqrr_front #(.NUM_IRQS(NUM_IRQS), .NUM_SOURCES(NUM_SOURCES)) u_front (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full),
        .command(command), .irq_number(irq_number), .cpu_mask(cpu_mask),
        .pending(pending), .self_cpu(self_cpu),
        .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd)
    );

    irqrr_back #(
        .NUM_CPUS(NUM_CPUS), .NUM_SLOTS(NUM_SLOTS),
        .NUM_IRQS(NUM_IRQS), .NUM_SOURCES(NUM_SOURCES)
    ) u_back (
        .clk(clk), .rst_n(rst_n),
        .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd),
        .cfg_valid(cfg_valid), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .pop(pop), .empty(empty), .res(res)
    );

    assign kind        = res.kind;
    assign slot        = res.slot;
    assign source      = res.source;
    assign handled_irq = res.irq;
    assign target_cpu  = res.cpu;
    assign last        = res.last;

endmodule

>>> sim/interrupt_round_robin_distributor_tb.sv
`timescale 1ns / 100ps

module interrupt_round_robin_distributor_tb;
    import irqrr_pkg::*;

    localparam int N_CPUS    = 16;
    localparam int N_SLOTS   = 26;
    localparam int N_IRQS    = 128;
    localparam int N_SOURCES = 64;
    localparam logic [5:0] SLOT_NONE = 6'd63;
    localparam logic [4:0] PTR_NONE  = 5'd16;

    typedef struct packed {
        logic [2:0] kind;
        logic [4:0] slot;
        logic [5:0] source;
        logic [6:0] irq;
        logic [3:0] cpu;
        logic       last;
    } outcome_t;

    class dispatch_scoreboard;
        logic [63:0] local_src;
        logic [15:0] active;
        logic [6:0]  base;
        logic [31:0] busy;
        logic [5:0]  slot_of [N_IRQS];
        logic [15:0] affinity [N_IRQS];
        logic [4:0]  apic_ptr [64];
        logic [4:0]  msi_ptr [64];
        outcome_t    pending_q [$];
        int          errors;

        function new();
            local_src = '0;
            active = 16'd1;
            base = '0;
            busy = '0;
            errors = 0;
            foreach (slot_of[i]) slot_of[i] = SLOT_NONE;
            foreach (affinity[i]) affinity[i] = 16'hFFFF;
            foreach (apic_ptr[i]) apic_ptr[i] = PTR_NONE;
            foreach (msi_ptr[i]) msi_ptr[i] = PTR_NONE;
        endfunction

        function void write_reg(logic [1:0] idx, logic [63:0] value);
            if (idx == CFG_LOCAL) local_src = value;
            else if (idx == CFG_ACTIVE) active = value[15:0];
            else if (idx == CFG_BASE) base = value[6:0];
        endfunction

        function logic [3:0] next_cpu(logic [4:0] ptr, logic [15:0] avail);
            int c;
            int first;
            first = (ptr >= PTR_NONE) ? 0 : ptr + 1;
            for (c = first; c < 16; c++)
                if (avail[c]) return c[3:0];
            for (c = 0; c < 16; c++)
                if (avail[c]) return c[3:0];
            return 4'd0;
        endfunction

        function void add(outcome_t o);
            pending_q.push_back(o);
        endfunction

        function void note_input(logic [2:0] cmd, logic [6:0] irq, logic [15:0] mask,
                                 logic [63:0] pend, logic [3:0] me);
            outcome_t o;
            int pos;
            int n;
            int idx;
            logic [5:0] sl;
            logic [15:0] avail;
            logic [3:0] tgt;
            bit msi;
            bit in_tab;
            n = 0;
            if (cmd == OP_CLAIM) begin
                pos = -1;
                for (int p = 0; p < N_SLOTS; p++)
                    if (pos < 0 && !busy[p]) pos = p;
                if (pos >= 0 && irq < N_IRQS) begin
                    busy[pos] = 1'b1;
                    slot_of[irq] = pos[5:0];
                    o = '{KIND_CLAIMED, pos[4:0], 6'd0, irq, 4'd0, 1'b1};
                end else
                    o = '{KIND_NO_SLOT, 5'd0, 6'd0, irq, 4'd0, 1'b1};
                add(o);
            end else if (cmd == OP_RELEASE) begin
                pos = 0;
                if (irq < N_IRQS && slot_of[irq] != SLOT_NONE) begin
                    pos = slot_of[irq];
                    busy[pos] = 1'b0;
                    slot_of[irq] = SLOT_NONE;
                end
                add('{KIND_RELEASED, pos[4:0], 6'd0, irq, 4'd0, 1'b1});
            end else if (cmd == OP_AFFINITY) begin
                if (irq < N_IRQS) affinity[irq] = mask;
            end else if (cmd == OP_APIC || cmd == OP_MSI) begin
                msi = (cmd == OP_MSI);
                for (int s = 0; s < N_SOURCES; s++) begin
                    if (!pend[s]) continue;
                    idx = msi ? s : base + s;
                    in_tab = idx < N_IRQS;
                    sl = in_tab ? slot_of[idx] : SLOT_NONE;
                    o = '{KIND_LOCAL, 5'd0, s[5:0], idx[6:0], me, 1'b0};
                    if (!msi && (local_src[s] || sl == SLOT_NONE)) begin
                        add(o);
                        n++;
                        continue;
                    end
                    avail = in_tab ? (affinity[idx] & active) : 16'd0;
                    if (avail != 0) begin
                        if (msi) begin
                            tgt = next_cpu(msi_ptr[s], avail);
                            msi_ptr[s] = {1'b0, tgt};
                        end else begin
                            tgt = next_cpu(apic_ptr[s], avail);
                            apic_ptr[s] = {1'b0, tgt};
                        end
                        if (tgt != me && sl != SLOT_NONE)
                            o = '{KIND_FORWARD, sl[4:0], s[5:0], idx[6:0], tgt, 1'b0};
                    end
                    add(o);
                    n++;
                end
                if (n > 0) pending_q[$].last = 1'b1;
            end
        endfunction

        function void check_result(outcome_t got);
            outcome_t want;
            if (pending_q.size() == 0) begin
                $error("result with no expectation: %p", got);
                errors++;
                return;
            end
            want = pending_q.pop_front();
            if (got.kind != want.kind) begin
                $error("kind: expected %0d, actual %0d", want.kind, got.kind); errors++;
            end
            if (got.slot != want.slot) begin
                $error("slot: expected %0d, actual %0d", want.slot, got.slot); errors++;
            end
            if (got.source != want.source) begin
                $error("source: expected %0d, actual %0d", want.source, got.source); errors++;
            end
            if (got.irq != want.irq) begin
                $error("handled_irq: expected %0d, actual %0d", want.irq, got.irq); errors++;
            end
            if (got.cpu != want.cpu) begin
                $error("target_cpu: expected %0d, actual %0d", want.cpu, got.cpu); errors++;
            end
            if (got.last != want.last) begin
                $error("last: expected %0d, actual %0d", want.last, got.last); errors++;
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    logic [2:0]  command = '0;
    logic [6:0]  irq_number = '0;
    logic [15:0] cpu_mask = '0;
    logic [63:0] pending = '0;
    logic [3:0]  self_cpu = '0;
    logic        pop = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [63:0] cfg_data = '0;
    logic        full, empty, cfg_ready, last;
    logic [2:0]  kind;
    logic [4:0]  slot;
    logic [5:0]  source;
    logic [6:0]  handled_irq;
    logic [3:0]  target_cpu;

    dispatch_scoreboard board = new();
    int stall_mode = 0;

    always #5 clk = ~clk;

    interrupt_round_robin_distributor i_dut (.*);

    // Receiver: pop pattern changes per phase, checking on each accepted beat.
    always @(posedge clk) begin
        if (rst_n) begin
            if (pop && !empty)
                board.check_result('{kind, slot, source, handled_irq, target_cpu, last});
            case (stall_mode)
                0: pop <= 1'b1;
                1: pop <= ($urandom_range(0, 3) != 0);
                default: pop <= ($urandom_range(0, 4) == 0);
            endcase
        end
    end

    task automatic send(logic [2:0] cmd, logic [6:0] irq, logic [15:0] mask,
                        logic [63:0] pend, logic [3:0] me);
        push <= 1'b1;
        command <= cmd;
        irq_number <= irq;
        cpu_mask <= mask;
        pending <= pend;
        self_cpu <= me;
        do @(posedge clk); while (full);
        board.note_input(cmd, irq, mask, pend, me);
    endtask

    task automatic pause_sender();
        push <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain();
        push <= 1'b0;
        while (board.pending_q.size() != 0) @(posedge clk);
        // Set affinity beats give no result, so leave room for the back end to finish.
        repeat (200) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [63:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge clk); while (!cfg_ready);
        board.write_reg(idx, value);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic logic [63:0] sparse64();
        logic [63:0] v;
        v = '0;
        repeat ($urandom_range(1, 5)) v[6'($urandom_range(0, 63))] = 1'b1;
        return v;
    endfunction

    task automatic random_item();
        int r;
        logic [6:0] irq;
        logic [15:0] m;
        logic [3:0] me;
        r = $urandom_range(0, 99);
        irq = (r % 3 == 0) ? 7'($urandom()) : 7'($urandom_range(0, 70));
        m = 16'($urandom());
        me = 4'($urandom());
        if (r < 22) send(OP_CLAIM, irq, m, rand64(), me);
        else if (r < 38) send(OP_RELEASE, irq, m, rand64(), me);
        else if (r < 52) send(OP_AFFINITY, irq, m, rand64(), me);
        else if (r < 74) send(OP_APIC, irq, m, (r < 70) ? sparse64() : rand64(), me);
        else if (r < 97) send(OP_MSI, irq, m, (r < 93) ? sparse64() : rand64(), me);
        else send(3'($urandom_range(5, 7)), irq, m, rand64(), me);
    endtask

    task automatic random_phase(int count);
        int left;
        left = count;
        while (left > 0) begin
            repeat ($urandom_range(1, 12)) begin
                if (left > 0) begin
                    random_item();
                    left--;
                end
            end
            if ($urandom_range(0, 2) != 0) pause_sender();
            repeat ($urandom_range(0, 6)) pause_sender();
        end
    endtask

    initial begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: claim slots, claim one IRQ a second time, and exercise the odd cases.
        for (int i = 0; i < 27; i += 3) send(OP_CLAIM, i[6:0], '0, '0, '0);
        send(OP_CLAIM, 7'd3, '0, '0, '0);
        send(OP_RELEASE, 7'd3, '0, '0, '0);
        send(OP_RELEASE, 7'd127, '0, '0, '0);
        send(OP_RELEASE, 7'd100, '0, '0, '0);
        send(OP_AFFINITY, 7'd3, 16'h0006, '0, '0);
        send(OP_AFFINITY, 7'd6, 16'h0000, '0, '0);
        send(OP_APIC, '0, '0, 64'hFFFF_FFFF_FFFF_FFFF, 4'd15);
        send(OP_MSI, '0, '0, 64'h0000_0000_0000_0049, 4'd0);
        send(OP_MSI, '0, '0, 64'h0000_0000_0000_0000, 4'd1);
        send(3'd7, '0, '0, 64'hFFFF, '0);
        drain();

        write_reg(CFG_ACTIVE, 64'hFFFF);
        write_reg(CFG_LOCAL, 64'h8000_0000_0000_0001);
        write_reg(CFG_BASE, 64'd64);
        repeat (15) send(OP_CLAIM, 7'($urandom_range(0, 127)), '0, '0, '0);
        send(OP_APIC, '0, '0, 64'hFFFF_FFFF_FFFF_FFFF, 4'd0);
        send(OP_MSI, '0, '0, 64'hFFFF_FFFF_FFFF_FFFF, 4'd15);
        send(OP_MSI, '0, '0, 64'hFFFF_FFFF_FFFF_FFFF, 4'd3);
        drain();

        for (int ph = 0; ph < 4; ph++) begin
            stall_mode = ph % 3;
            write_reg(CFG_LOCAL, (ph == 3) ? 64'd0 : rand64());
            write_reg(CFG_ACTIVE, (ph == 2) ? 64'd0 : {48'd0, 16'($urandom())});
            write_reg(CFG_BASE, (ph == 1) ? 64'd0 : 64'($urandom_range(0, 64)));
            random_phase(28);
            drain();
        end
        stall_mode = 0;
        drain();

        if (board.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial begin
        #20ms;
        $display("simulation failed");
        $finish;
    end
endmodule
